// ----- rtl/core/gcd_lcm_unit_macros.svh -----
// gcd_lcm_unit_macros.svh: assertion macros shared by the gcd/lcm rtl
// no dependencies; included by modules that carry assertions
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define GLU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/glu_pkg.sv -----
// glu_pkg: constants for the gcd/lcm unit
// no dependencies; imported by gcd_lcm_unit and gcd_lcm_unit_test
package glu_pkg;

    // default internal operand width
    localparam int unsigned OPERAND_WIDTH_DEF = 16;

    // fixed field widths of the ports
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned GCD_W   = 16;
    localparam int unsigned LCM_W   = 32;

endpackage

// ----- rtl/core/gcd_lcm_unit.sv -----
// gcd_lcm_unit: greatest common divisor and least common multiple of two operands
// depends on glu_pkg and gcd_lcm_unit_macros.svh
//
// One operand pair is taken at a time and yields one result. A pair with a zero
// operand gives zero results and o_zero_operand set, going from the idle state
// straight to the finish state. Otherwise the pair goes through one shared
// (W+1)-bit adder/subtractor under a sequencer: binary gcd (common factors of two
// stripped, then shift and subtract), a shift of the common power of two back in,
// a restoring division a/gcd and a shift-add multiply by b. Only the low
// OPERAND_WIDTH bits of each operand are used, and the results are truncated to
// their field widths. A finished result waits in the output register and the next
// pair may be taken meanwhile.
`include "gcd_lcm_unit_macros.svh"

module gcd_lcm_unit
    import glu_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [VALUE_W-1:0] i_value_a,
    input  logic [VALUE_W-1:0] i_value_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [GCD_W-1:0]   o_greatest_divisor,
    output logic [LCM_W-1:0]   o_least_multiple,
    output logic               o_zero_operand
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned AW = W + 1;
    localparam int unsigned KW = $clog2(W);
    localparam int unsigned CW = $clog2(W);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_TWOS    = 3'd1;
    localparam logic [2:0] ST_REDUCE  = 3'd2;
    localparam logic [2:0] ST_RESTORE = 3'd3;
    localparam logic [2:0] ST_DIVIDE  = 3'd4;
    localparam logic [2:0] ST_MULT    = 3'd5;
    localparam logic [2:0] ST_FINISH  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [W-1:0]     r_a, n_a;
    logic [W-1:0]     r_b, n_b;
    logic [W-1:0]     r_opa, n_opa;
    logic [W-1:0]     r_opb, n_opb;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [KW-1:0]    r_k, n_k;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_err, n_err;
    logic             r_out_valid, n_out_valid;
    logic [GCD_W-1:0] r_gcd_out, n_gcd_out;
    logic [LCM_W-1:0] r_lcm_out, n_lcm_out;
    logic             r_zero_out, n_zero_out;

    // operand fit to the internal width
    logic [W+VALUE_W-1:0] ext_a, ext_b;
    logic [W-1:0]         in_a, in_b;

    // shared adder/subtractor
    logic [AW-1:0] add_x, add_y;
    logic          add_inv, add_cin;
    logic [AW:0]   add_s;

    // result fitting
    logic [W+GCD_W-1:0]   gcd_ext;
    logic [2*W+LCM_W-1:0] lcm_ext;

    logic in_xfer, last_step, slot_free;

    assign ext_a = {{W{1'b0}}, i_value_a};
    assign ext_b = {{W{1'b0}}, i_value_b};
    assign in_a  = ext_a[W-1:0];
    assign in_b  = ext_b[W-1:0];

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign last_step  = (r_cnt == CW'(W - 1));
    assign slot_free  = !r_out_valid || i_out_ready;

    assign gcd_ext = {{GCD_W{1'b0}}, r_b};
    assign lcm_ext = {{LCM_W{1'b0}}, r_rem, r_quo};

    // adder operand select per state
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_inv = 1'b0;
        add_cin = 1'b0;
        unique case (r_state)
            ST_REDUCE: begin
                add_x   = {1'b0, r_a};
                add_y   = {1'b0, r_b};
                add_inv = 1'b1;
                add_cin = 1'b1;
            end
            ST_DIVIDE: begin
                add_x   = {r_rem, r_quo[W-1]};
                add_y   = {1'b0, r_b};
                add_inv = 1'b1;
                add_cin = 1'b1;
            end
            ST_MULT: begin
                add_x = {1'b0, r_rem};
                add_y = r_quo[0] ? {1'b0, r_opb} : '0;
            end
            default: begin
            end
        endcase
    end

    assign add_s = {1'b0, add_x} + {1'b0, add_inv ? ~add_y : add_y} + {{AW{1'b0}}, add_cin};

    // sequencer next state and datapath
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_gcd_out   = r_gcd_out;
        n_lcm_out   = r_lcm_out;
        n_zero_out  = r_zero_out;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_a   = in_a;
                    n_b   = in_b;
                    n_opa = in_a;
                    n_opb = in_b;
                    n_k   = '0;
                    n_err = (in_a == '0) || (in_b == '0);
                    n_state = n_err ? ST_FINISH : ST_TWOS;
                end
            end
            // strip common factors of two
            ST_TWOS: begin
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + KW'(1);
                end else begin
                    n_state = ST_REDUCE;
                end
            end
            // binary gcd on the odd part, gcd ends up in r_b
            ST_REDUCE: begin
                priority if (r_a == '0) begin
                    n_state = ST_RESTORE;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (add_s[AW]) begin
                    n_a = add_s[W-1:0];
                end else begin
                    n_a = r_b;
                    n_b = r_a;
                end
            end
            // shift the common power of two back in
            ST_RESTORE: begin
                if (r_k != '0) begin
                    n_b = r_b << 1;
                    n_k = r_k - KW'(1);
                end else begin
                    n_rem   = '0;
                    n_quo   = r_opa;
                    n_cnt   = '0;
                    n_state = ST_DIVIDE;
                end
            end
            // restoring division a / gcd, quotient shifts into r_quo
            ST_DIVIDE: begin
                n_rem = add_s[AW] ? add_s[W-1:0] : add_x[W-1:0];
                n_quo = {r_quo[W-2:0], add_s[AW]};
                n_cnt = r_cnt + CW'(1);
                if (last_step) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_MULT;
                end
            end
            // shift-add multiply quotient * b, product in {r_rem, r_quo}
            ST_MULT: begin
                n_rem = add_s[W:1];
                n_quo = {add_s[0], r_quo[W-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (last_step) begin
                    n_state = ST_FINISH;
                end
            end
            // load the output register once it is free
            ST_FINISH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_zero_out  = r_err;
                    n_gcd_out   = r_err ? '0 : gcd_ext[GCD_W-1:0];
                    n_lcm_out   = r_err ? '0 : lcm_ext[LCM_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_err      <= n_err;
        r_gcd_out  <= n_gcd_out;
        r_lcm_out  <= n_lcm_out;
        r_zero_out <= n_zero_out;
    end

    assign o_out_valid        = r_out_valid;
    assign o_greatest_divisor = r_gcd_out;
    assign o_least_multiple   = r_lcm_out;
    assign o_zero_operand     = r_zero_out;

    // checks
    `GLU_ASSERT_NOW(a_reduce_b_nonzero, r_state == ST_REDUCE, r_b != '0,
                    "gcd loop lost its odd operand")
    `GLU_ASSERT_NOW(a_finish_gcd_nonzero, r_state == ST_FINISH && !r_err, r_b != '0,
                    "zero gcd for nonzero operands")
    `GLU_ASSERT_NOW(a_zero_results, o_out_valid && o_zero_operand,
                    o_greatest_divisor == '0 && o_least_multiple == '0,
                    "zero operand with nonzero results")
    `GLU_ASSERT_NEXT(a_busy_after_xfer, in_xfer, r_state != ST_IDLE,
                     "sequencer idle right after an input transfer")

endmodule

// ----- tb/gcd_lcm_unit_test.sv -----
// gcd_lcm_unit_test: self-checking bench for the gcd/lcm unit, directed then random pairs
// depends on glu_pkg and gcd_lcm_unit; predicts each result with euclid's algorithm
// a queue-fed driver and a checking monitor run with random idle on both channels
module gcd_lcm_unit_test
    import glu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OPW        = OPERAND_WIDTH_DEF;
    localparam int          N_RANDOM   = 930;
    localparam int          IDLE_PCT   = 29;
    localparam int          TAIL_WAIT  = 200;

    typedef struct {
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
    } t_operand_pair;

    typedef struct {
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [GCD_W-1:0]   gcd;
        logic [LCM_W-1:0]   lcm;
        logic               zero;
    } t_gcd_lcm_result;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    logic [VALUE_W-1:0] value_a    = '0;
    logic [VALUE_W-1:0] value_b    = '0;
    logic               out_ready  = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [GCD_W-1:0]   o_greatest_divisor;
    logic [LCM_W-1:0]   o_least_multiple;
    logic               o_zero_operand;

    t_operand_pair   pairs_to_send[$];
    t_gcd_lcm_result pending_results[$];
    int unsigned     n_accepted = 0;
    int unsigned     n_results  = 0;
    int              n_errors   = 0;

    gcd_lcm_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_value_a          (value_a),
        .i_value_b          (value_b),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_greatest_divisor (o_greatest_divisor),
        .o_least_multiple   (o_least_multiple),
        .o_zero_operand     (o_zero_operand)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // euclid gcd and lcm of one pair, zero operand flagged
    function automatic t_gcd_lcm_result gcd_lcm_of(logic [VALUE_W-1:0] a_in,
                                                   logic [VALUE_W-1:0] b_in);
        t_gcd_lcm_result  res;
        longint unsigned  mask;
        longint unsigned  x;
        longint unsigned  y;
        longint unsigned  r;
        longint unsigned  l;
        mask     = (64'd1 << OPW) - 64'd1;
        x        = longint'(a_in) & mask;
        y        = longint'(b_in) & mask;
        res.a    = a_in;
        res.b    = b_in;
        res.gcd  = '0;
        res.lcm  = '0;
        res.zero = 1'b0;
        if (x == 0 || y == 0) begin
            res.zero = 1'b1;
        end else begin
            l = y;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            l       = ((longint'(a_in) & mask) / x) * l;
            res.gcd = x[GCD_W-1:0];
            res.lcm = l[LCM_W-1:0];
        end
        return res;
    endfunction

    // random pair, mostly nonzero with structure, some zeros
    function automatic t_operand_pair random_pair();
        t_operand_pair p;
        int unsigned   mode;
        int unsigned   g;
        int unsigned   k;
        mode = $urandom_range(0, 99);
        if (mode < 35) begin
            p.a = 16'($urandom());
            p.b = 16'($urandom());
        end else if (mode < 60) begin
            // shared factor
            g   = $urandom_range(1, 300);
            p.a = 16'(g * $urandom_range(1, 65535 / g));
            p.b = 16'(g * $urandom_range(1, 65535 / g));
        end else if (mode < 75) begin
            p.a = 16'($urandom_range(1, 64));
            p.b = 16'($urandom_range(1, 64));
        end else if (mode < 85) begin
            // powers of two times odd
            k   = $urandom_range(0, 10);
            p.a = 16'((($urandom_range(0, 31) << 1) | 1) << k);
            p.b = 16'((($urandom_range(0, 31) << 1) | 1) << $urandom_range(0, 10));
        end else if (mode < 93) begin
            // one divides the other
            p.a = 16'($urandom_range(1, 255));
            p.b = 16'(32'(p.a) * $urandom_range(1, 65535 / p.a));
            if ($urandom_range(0, 1)) begin
                g   = 32'(p.a);
                p.a = p.b;
                p.b = 16'(g);
            end
        end else begin
            // zero operand
            p.a = $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom());
            p.b = p.a != 0 ? 16'd0 : ($urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom()));
        end
        return p;
    endfunction

    // stimulus: directed corners, then random pairs
    initial begin : stimulus
        logic [VALUE_W-1:0] corners[$];
        t_operand_pair      p;
        corners = '{16'd0, 16'd0,  16'd0, 16'd77,  16'd1234, 16'd0,
                    16'd1, 16'd1,  16'hFFFF, 16'hFFFF,  16'hFFFF, 16'hFFFE,
                    16'd65521, 16'd65519,  16'h8000, 16'h4000,  16'h8000, 16'd1,
                    16'd1, 16'hFFFF,  16'hFFFF, 16'd1,  16'd48, 16'd36,
                    16'hAAAA, 16'h5555,  16'h5555, 16'hAAAA,  16'd4096, 16'd4096,
                    16'd0, 16'hFFFF,  16'hFFFF, 16'd0,  16'd12, 16'd18,
                    16'd17, 16'd65535,  16'd510, 16'd255,  16'd2, 16'd3,
                    16'hFF00, 16'h00FF,  16'd360, 16'd1024};
        for (int i = 0; i < corners.size(); i += 2) begin
            p.a = corners[i];
            p.b = corners[i + 1];
            pairs_to_send.push_back(p);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            pairs_to_send.push_back(random_pair());
        end
    end

    // reset, then wait for the last result and report
    initial begin : run_control
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pairs_to_send.size() != 0 || in_valid || n_results != n_accepted) begin
            @(posedge i_clk);
        end
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected none outstanding",
                     $time, pending_results.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // driver: input transfers with random idle and two drain pauses
    always @(posedge i_clk) begin : driver
        int unsigned   issued;
        bit            hold;
        bit            idle;
        t_operand_pair p;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            issued = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || o_in_ready) begin
                hold = (issued == 23 || issued == 600) &&
                       (in_valid || n_results != n_accepted);
                idle = !(issued >= 400 && issued < 550) &&
                       ($urandom_range(0, 99) < IDLE_PCT);
                if (pairs_to_send.size() != 0 && !hold && !idle) begin
                    p = pairs_to_send.pop_front();
                    in_valid <= 1'b1;
                    value_a  <= p.a;
                    value_b  <= p.b;
                    issued++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin : monitor
        t_gcd_lcm_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                pending_results.push_back(gcd_lcm_of(value_a, value_b));
            end
            if (o_out_valid && out_ready) begin
                n_results <= n_results + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got gcd %0d lcm %0d zero %0b",
                             $time, o_greatest_divisor, o_least_multiple, o_zero_operand);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_greatest_divisor !== want.gcd) begin
                        $display("%0t: gcd(%0d,%0d) expected %0d, got %0d", $time,
                                 want.a, want.b, want.gcd, o_greatest_divisor);
                        n_errors++;
                    end
                    if (o_least_multiple !== want.lcm) begin
                        $display("%0t: lcm(%0d,%0d) expected %0d, got %0d", $time,
                                 want.a, want.b, want.lcm, o_least_multiple);
                        n_errors++;
                    end
                    if (o_zero_operand !== want.zero) begin
                        $display("%0t: zero flag (%0d,%0d) expected %0b, got %0b", $time,
                                 want.a, want.b, want.zero, o_zero_operand);
                        n_errors++;
                    end
                end
            end
            // random back-pressure, none in the quiet stretch
            if (n_results >= 400 && n_results < 550) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

endmodule
